[sv/bms_pkg.sv]
// Package for the battery mode supervisor: transaction and state structs,
// mode, init phase and fault codes, register map and reset values.
// No dependencies.
package bms_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 4;

    localparam logic [2:0] MODE_INIT      = 3'd0;
    localparam logic [2:0] MODE_STANDBY   = 3'd1;
    localparam logic [2:0] MODE_CHARGE    = 3'd2;
    localparam logic [2:0] MODE_DISCHARGE = 3'd3;
    localparam logic [2:0] MODE_BALANCE   = 3'd4;
    localparam logic [2:0] MODE_ERROR     = 3'd5;

    localparam logic [1:0] PHASE_OFF   = 2'd0;
    localparam logic [1:0] PHASE_READ  = 2'd1;
    localparam logic [1:0] PHASE_CHECK = 2'd2;
    localparam logic [1:0] PHASE_DONE  = 2'd3;

    localparam logic [2:0] FAULT_NONE      = 3'd0;
    localparam logic [2:0] FAULT_STORAGE   = 3'd1;
    localparam logic [2:0] FAULT_MONITOR   = 3'd2;
    localparam logic [2:0] FAULT_OVERTEMP  = 3'd3;
    localparam logic [2:0] FAULT_UNDERVOLT = 3'd4;
    localparam logic [2:0] FAULT_OVERVOLT  = 3'd5;
    localparam logic [2:0] FAULT_SUBSTEP   = 3'd6;

    localparam logic [1:0] REG_TEMP_LIMIT = 2'd0;
    localparam logic [1:0] REG_CELL_MIN   = 2'd1;
    localparam logic [1:0] REG_CELL_MAX   = 2'd2;

    localparam logic [7:0]  TEMP_LIMIT_RESET = 8'd60;
    localparam logic [15:0] CELL_MIN_RESET   = 16'd2500;
    localparam logic [15:0] CELL_MAX_RESET   = 16'd4200;

    typedef struct packed {
        logic [7:0]  temp_limit_c;
        logic [15:0] cell_min_limit_mv;
        logic [15:0] cell_max_limit_mv;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  mode_req;
        logic        config_read_done;
        logic        config_check_done;
        logic        storage_read_error;
        logic        monitor_error;
        logic [7:0]  hottest_cell_c;
        logic [15:0] lowest_cell_mv;
        logic [15:0] highest_cell_mv;
        logic        charge_done;
        logic        discharge_done;
        logic        substep_fault;
    } tick_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] init_phase;
        logic [2:0] fault_code;
        logic       request_config_read;
        logic       request_config_check;
        logic       run_charge_step;
        logic       run_discharge_step;
        logic       safe_shutdown;
    } result_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] phase;
        logic [2:0] fault;
        logic       read_req;
        logic       check_req;
    } state_t;

endpackage

[sv/bms_cfg_regs.sv]
// Limit registers behind the APB-style configuration port.
// Depends on bms_pkg.
module bms_cfg_regs
    import bms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_limit_c      <= TEMP_LIMIT_RESET;
            cfg_reg.cell_min_limit_mv <= CELL_MIN_RESET;
            cfg_reg.cell_max_limit_mv <= CELL_MAX_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TEMP_LIMIT: cfg_reg.temp_limit_c      <= pwdata[7:0];
                REG_CELL_MIN:   cfg_reg.cell_min_limit_mv <= pwdata[15:0];
                REG_CELL_MAX:   cfg_reg.cell_max_limit_mv <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TEMP_LIMIT: prdata = {{(DATA_W-8){1'b0}}, cfg_reg.temp_limit_c};
            REG_CELL_MIN:   prdata = {{(DATA_W-16){1'b0}}, cfg_reg.cell_min_limit_mv};
            REG_CELL_MAX:   prdata = {{(DATA_W-16){1'b0}}, cfg_reg.cell_max_limit_mv};
            default:        prdata = '0;
        endcase
    end

endmodule

[sv/bms_step.sv]
// One supervisor tick: fault priority check, mode transition, dispatch.
// Combinational; depends on bms_pkg.
module bms_step
    import bms_pkg::*;
(
    input  state_t  state,
    input  tick_t   tick,
    input  cfg_t    cfg,
    output state_t  state_next,
    output result_t result
);

    logic [2:0] fcode;
    logic [2:0] mode_chk;
    logic [2:0] fault_chk;
    logic       move_ok;
    logic       swap_ok;
    logic       done_ok;

    always_comb
    begin
        if (tick.storage_read_error)
            fcode = FAULT_STORAGE;
        else if (tick.monitor_error)
            fcode = FAULT_MONITOR;
        else if (tick.hottest_cell_c > cfg.temp_limit_c)
            fcode = FAULT_OVERTEMP;
        else if (tick.lowest_cell_mv <= cfg.cell_min_limit_mv)
            fcode = FAULT_UNDERVOLT;
        else if (tick.highest_cell_mv >= cfg.cell_max_limit_mv)
            fcode = FAULT_OVERVOLT;
        else
            fcode = FAULT_NONE;
    end

    // no fault check in init, error is sticky
    always_comb
    begin
        mode_chk  = state.mode;
        fault_chk = state.fault;
        if (state.mode != MODE_INIT && state.mode != MODE_ERROR && fcode != FAULT_NONE)
        begin
            mode_chk  = MODE_ERROR;
            fault_chk = fcode;
        end
    end

    always_comb
    begin
        case (mode_chk)
            MODE_STANDBY:
                move_ok = tick.mode_req == MODE_CHARGE
                       || tick.mode_req == MODE_BALANCE
                       || tick.mode_req == MODE_DISCHARGE;
            MODE_CHARGE, MODE_BALANCE, MODE_DISCHARGE:
                move_ok = tick.mode_req == MODE_STANDBY;
            default:
                move_ok = 1'b0;
        endcase
        case (mode_chk)
            MODE_CHARGE:    done_ok = tick.charge_done;
            MODE_DISCHARGE: done_ok = tick.discharge_done;
            MODE_INIT:      done_ok = state.phase == PHASE_DONE;
            MODE_ERROR:     done_ok = 1'b0;
            default:        done_ok = 1'b1;
        endcase
        swap_ok = (mode_chk == MODE_BALANCE && tick.mode_req == MODE_CHARGE)
               || (mode_chk == MODE_CHARGE && tick.mode_req == MODE_BALANCE);
    end

    always_comb
    begin
        state_next       = state;
        state_next.mode  = mode_chk;
        state_next.fault = fault_chk;
        result           = '0;

        if ((move_ok && done_ok) || swap_ok)
            state_next.mode = tick.mode_req;

        case (state_next.mode)
            MODE_INIT:
            begin
                case (state.phase)
                    PHASE_OFF:
                    begin
                        state_next.read_req = 1'b1;
                        state_next.phase    = PHASE_READ;
                    end
                    PHASE_READ:
                    begin
                        if (tick.config_read_done)
                        begin
                            state_next.read_req  = 1'b0;
                            state_next.check_req = 1'b1;
                            state_next.phase     = PHASE_CHECK;
                        end
                    end
                    PHASE_CHECK:
                    begin
                        if (tick.config_check_done)
                        begin
                            state_next.check_req = 1'b0;
                            state_next.phase     = PHASE_DONE;
                            state_next.mode      = MODE_STANDBY;
                        end
                    end
                    default:
                        state_next.mode = MODE_STANDBY;
                endcase
            end
            MODE_CHARGE, MODE_BALANCE:
            begin
                result.run_charge_step = 1'b1;
                if (tick.substep_fault)
                begin
                    state_next.mode  = MODE_ERROR;
                    state_next.fault = FAULT_SUBSTEP;
                end
            end
            MODE_DISCHARGE:
            begin
                result.run_discharge_step = 1'b1;
                if (tick.substep_fault)
                begin
                    state_next.mode  = MODE_ERROR;
                    state_next.fault = FAULT_SUBSTEP;
                end
            end
            MODE_ERROR:
            begin
                state_next.read_req  = 1'b0;
                state_next.check_req = 1'b0;
                result.safe_shutdown = 1'b1;
            end
            default: ;
        endcase

        result.mode                 = state_next.mode;
        result.init_phase           = state_next.phase;
        result.fault_code           = state_next.fault;
        result.request_config_read  = state_next.read_req;
        result.request_config_check = state_next.check_req;
    end

endmodule

[sv/battery_mode_supervisor.sv]
// Battery mode supervisor top level: input register, one-tick step logic, result register.
// A tick passes the input register, the step logic and the result register; throughput is one tick
// per cycle while result_stall is low, set by the single state register that each tick reads and updates.
// rst_n (async, active low) puts the block in init mode, phase off, no fault,
// request flags low, limits at 60 C / 2500 mV / 4200 mV, both pipeline stages empty.
// Depends on bms_pkg, bms_cfg_regs and bms_step.
module battery_mode_supervisor
    import bms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick_valid,
    output logic              tick_stall,
    input  tick_t             tick,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t    cfg;
    tick_t   tick_reg;
    logic    tick_valid_reg;
    result_t result_reg;
    logic    result_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t step_result;
    logic    advance;
    logic    load_in;

    bms_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bms_step u_step (
        .state      (state_reg),
        .tick       (tick_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .result     (step_result)
    );

    assign advance      = tick_valid_reg && (!result_valid_reg || !result_stall);
    assign load_in      = !tick_valid_reg || advance;
    assign tick_stall   = !load_in;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '{mode: MODE_INIT, phase: PHASE_OFF,
                                  fault: FAULT_NONE, read_req: 1'b0, check_req: 1'b0};
        end
        else
        begin
            if (load_in)
                tick_valid_reg <= tick_valid;
            if (advance)
            begin
                state_reg        <= state_next;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in && tick_valid)
            tick_reg <= tick;
        if (advance)
            result_reg <= step_result;
    end

    a_fault_iff_error: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.fault != FAULT_NONE) == (state_reg.mode == MODE_ERROR))
        else $error("latched fault and error mode disagree");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.mode == MODE_ERROR |=> state_reg.mode == MODE_ERROR)
        else $error("left error mode");

    a_init_until_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase != PHASE_DONE |-> state_reg.mode == MODE_INIT)
        else $error("left init mode before init sequence finished");

    a_shutdown_mode: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.safe_shutdown |-> result_reg.mode == MODE_ERROR)
        else $error("safe shutdown outside error mode");

    a_one_substep: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(result_reg.run_charge_step && result_reg.run_discharge_step))
        else $error("charge and discharge stepped together");

endmodule

[sim/supervisor_checker.sv]
`timescale 1ns / 1ps
// Checker for battery_mode_supervisor: mirrors the mode state and the limit registers,
// predicts one result per accepted tick transaction and compares results in order.
// Depends on bms_pkg.
module supervisor_checker
    import bms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick_valid,
    input  logic              tick_stall,
    input  tick_t             tick,
    input  logic              result_valid,
    input  logic              result_stall,
    input  result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                mismatches,
    output int                outstanding
);

    cfg_t    limits;
    state_t  st;
    result_t predicted_results[$];
    int      error_count = 0;

    function automatic string show(input result_t r);
        return $sformatf("mode %0d phase %0d fault %0d rd %0b ck %0b chg %0b dis %0b shut %0b",
                         r.mode, r.init_phase, r.fault_code, r.request_config_read,
                         r.request_config_check, r.run_charge_step, r.run_discharge_step,
                         r.safe_shutdown);
    endfunction

    function automatic result_t supervise_tick(input tick_t t);
        result_t    r;
        logic [2:0] req;
        logic [2:0] trip;
        logic       take;
        logic       sub_err;
        r = '0;
        req = t.mode_req;
        trip = FAULT_NONE;
        sub_err = 1'b0;

        // fault priority: storage, monitor, temperature, undervoltage, overvoltage
        if (st.mode != MODE_INIT && st.mode != MODE_ERROR) begin
            if (t.storage_read_error)
                trip = FAULT_STORAGE;
            else if (t.monitor_error)
                trip = FAULT_MONITOR;
            else if (t.hottest_cell_c > limits.temp_limit_c)
                trip = FAULT_OVERTEMP;
            else if (t.lowest_cell_mv <= limits.cell_min_limit_mv)
                trip = FAULT_UNDERVOLT;
            else if (t.highest_cell_mv >= limits.cell_max_limit_mv)
                trip = FAULT_OVERVOLT;
        end
        if (trip != FAULT_NONE)
        begin
            st.mode = MODE_ERROR;
            st.fault = trip;
        end

        case (st.mode)
            MODE_STANDBY:
                take = req == MODE_CHARGE || req == MODE_BALANCE || req == MODE_DISCHARGE;
            MODE_CHARGE:
                take = (req == MODE_STANDBY && t.charge_done) || req == MODE_BALANCE;
            MODE_BALANCE:
                take = req == MODE_STANDBY || req == MODE_CHARGE;
            MODE_DISCHARGE:
                take = req == MODE_STANDBY && t.discharge_done;
            default:
                take = 1'b0;
        endcase
        if (take)
            st.mode = req;

        case (st.mode)
            MODE_INIT:
                case (st.phase)
                    PHASE_OFF:
                    begin
                        st.read_req = 1'b1;
                        st.phase = PHASE_READ;
                    end
                    PHASE_READ:
                        if (t.config_read_done)
                        begin
                            st.read_req = 1'b0;
                            st.check_req = 1'b1;
                            st.phase = PHASE_CHECK;
                        end
                    PHASE_CHECK:
                        if (t.config_check_done)
                        begin
                            st.check_req = 1'b0;
                            st.phase = PHASE_DONE;
                            st.mode = MODE_STANDBY;
                        end
                    default:
                        st.mode = MODE_STANDBY;
                endcase
            MODE_CHARGE, MODE_BALANCE:
            begin
                r.run_charge_step = 1'b1;
                sub_err = t.substep_fault;
            end
            MODE_DISCHARGE:
            begin
                r.run_discharge_step = 1'b1;
                sub_err = t.substep_fault;
            end
            MODE_ERROR:
            begin
                st.read_req = 1'b0;
                st.check_req = 1'b0;
                r.safe_shutdown = 1'b1;
            end
            default: ;
        endcase

        // sub-step error lands after dispatch, shutdown shows from the next tick
        if (sub_err)
        begin
            st.mode = MODE_ERROR;
            st.fault = FAULT_SUBSTEP;
        end

        r.mode = st.mode;
        r.init_phase = st.phase;
        r.fault_code = st.fault;
        r.request_config_read = st.read_req;
        r.request_config_check = st.check_req;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t exp_r;
        if (!rst_n)
        begin
            limits = '{TEMP_LIMIT_RESET, CELL_MIN_RESET, CELL_MAX_RESET};
            st = '{MODE_INIT, PHASE_OFF, FAULT_NONE, 1'b0, 1'b0};
            predicted_results.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                case (paddr[3:2])
                    REG_TEMP_LIMIT: limits.temp_limit_c = pwdata[7:0];
                    REG_CELL_MIN:   limits.cell_min_limit_mv = pwdata[15:0];
                    REG_CELL_MAX:   limits.cell_max_limit_mv = pwdata[15:0];
                    default: ;
                endcase

            if (result_valid && !result_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: result transaction with none expected: %s",
                                 $time, show(result));
                end
                else
                begin
                    exp_r = predicted_results.pop_front();
                    if (result !== exp_r)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("%0t: mismatch, expected {%s} got {%s}",
                                     $time, show(exp_r), show(result));
                    end
                end
            end

            if (tick_valid && !tick_stall)
                predicted_results.push_back(supervise_tick(tick));
        end
        mismatches <= error_count;
        outstanding <= predicted_results.size();
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for battery_mode_supervisor: clock, reset, limit register writes,
// tick stimulus with random gaps, a randomly stalling result side and the verdict.
// Depends on bms_pkg, battery_mode_supervisor and supervisor_checker.
module tb_top;
    import bms_pkg::*;

    localparam int         CYCLE_LIMIT = 800000;
    localparam logic [1:0] REG_UNUSED  = 2'd3;
    localparam logic [2:0] REQ_SPARE6  = 3'd6;
    localparam logic [2:0] REQ_SPARE7  = 3'd7;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              tick_valid;
    logic              tick_stall;
    tick_t             tick;
    logic              result_valid;
    logic              result_stall;
    result_t           result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                mismatches;
    int                outstanding;
    int                cycles = 0;
    bit                quiet = 1'b0;
    bit                hold_req = 1'b0;
    logic [7:0]        temp_lim;
    logic [15:0]       min_lim;
    logic [15:0]       max_lim;

    battery_mode_supervisor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    supervisor_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial
    begin : result_side
        int   span;
        int   pick;
        logic stall_now;
        bit   held;
        held = 1'b0;
        forever
        begin
            pick = $urandom_range(0, 99);
            if (hold_req && !held)
            begin
                held = 1'b1;
                stall_now = 1'b1;
                span = 400;
            end
            else if (quiet || pick < 70)
            begin
                stall_now = 1'b0;
                span = $urandom_range(1, 12);
            end
            else
            begin
                stall_now = 1'b1;
                span = (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            end
            result_stall <= stall_now;
            repeat (span) @(posedge clk);
        end
    end

    task automatic send_tick(input tick_t t);
        int pick;
        tick <= t;
        tick_valid <= 1'b1;
        do @(posedge clk); while (tick_stall);
        pick = $urandom_range(0, 99);
        if (!quiet && pick >= 65)
        begin
            tick_valid <= 1'b0;
            repeat ((pick < 96) ? $urandom_range(1, 3) : $urandom_range(10, 30)) @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        tick_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({index, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // upper data bits carry junk, only the register width counts
    task automatic set_limits(input logic [7:0] t_c, input logic [15:0] lo_mv,
                              input logic [15:0] hi_mv);
        write_reg(REG_TEMP_LIMIT, {24'($urandom), t_c});
        write_reg(REG_CELL_MIN, {16'($urandom), lo_mv});
        write_reg(REG_CELL_MAX, {16'($urandom), hi_mv});
        temp_lim = t_c;
        min_lim = lo_mv;
        max_lim = hi_mv;
    endtask

    function automatic logic [15:0] limit_pick(input logic [15:0] ceiling);
        case ($urandom_range(0, 2))
            0: return '0;
            1: return ceiling;
            default: return 16'($urandom_range(0, ceiling));
        endcase
    endfunction

    function automatic logic [2:0] pick_request();
        int p;
        p = $urandom_range(0, 99);
        if (p < 25)
            return MODE_STANDBY;
        if (p < 45)
            return MODE_CHARGE;
        if (p < 65)
            return MODE_DISCHARGE;
        if (p < 85)
            return MODE_BALANCE;
        return 3'($urandom_range(0, 7));
    endfunction

    // readings inside the current limits, boundaries often, no error flags
    function automatic tick_t healthy_tick(input logic [2:0] req);
        tick_t       t;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        t = raw[$bits(tick_t)-1:0];
        t.mode_req = req;
        t.storage_read_error = 1'b0;
        t.monitor_error = 1'b0;
        t.substep_fault = 1'b0;
        t.hottest_cell_c = ($urandom_range(0, 4) == 0) ? temp_lim
                         : 8'($urandom_range(0, temp_lim));
        t.lowest_cell_mv = ($urandom_range(0, 4) == 0) ? 16'(min_lim + 1)
                         : 16'($urandom_range(int'(min_lim) + 1, 65535));
        t.highest_cell_mv = ($urandom_range(0, 4) == 0) ? 16'(max_lim - 1)
                          : 16'($urandom_range(0, int'(max_lim) - 1));
        return t;
    endfunction

    task automatic walk(input logic [2:0] req, input logic chg_done, input logic dis_done,
                        input logic sub_fault);
        tick_t t;
        t = healthy_tick(req);
        t.charge_done = chg_done;
        t.discharge_done = dis_done;
        t.substep_fault = sub_fault;
        send_tick(t);
    endtask

    task automatic run_healthy(input int n);
        repeat (n) send_tick(healthy_tick(pick_request()));
    endtask

    initial
    begin : stimulus
        logic [63:0] raw;
        tick_t       t;
        rst_n <= 1'b0;
        tick_valid <= 1'b0;
        tick <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        temp_lim = TEMP_LIMIT_RESET;
        min_lim = CELL_MIN_RESET;
        max_lim = CELL_MAX_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // init sequence; readings, error flags and requests are ignored here
        raw = {$urandom, $urandom};
        t = raw[$bits(tick_t)-1:0];
        t.mode_req = MODE_ERROR;
        t.storage_read_error = 1'b1;
        t.monitor_error = 1'b1;
        t.hottest_cell_c = 8'hFF;
        t.lowest_cell_mv = '0;
        t.highest_cell_mv = 16'hFFFF;
        t.config_read_done = 1'b1;
        t.config_check_done = 1'b1;
        t.substep_fault = 1'b1;
        send_tick(t);
        t.mode_req = REQ_SPARE7;
        t.config_read_done = 1'b0;
        t.hottest_cell_c = '0;
        t.lowest_cell_mv = 16'hFFFF;
        t.highest_cell_mv = '0;
        send_tick(t);
        t.config_read_done = 1'b1;
        t.config_check_done = 1'b0;
        send_tick(t);
        t.config_read_done = 1'b0;
        send_tick(t);
        t.config_check_done = 1'b1;
        send_tick(t);

        // standby: refused requests, stray sub-step errors ignored
        walk(MODE_STANDBY, 1'b0, 1'b0, 1'b1);
        walk(MODE_INIT, 1'b0, 1'b0, 1'b1);
        walk(REQ_SPARE6, 1'b0, 1'b0, 1'b1);
        walk(REQ_SPARE7, 1'b0, 1'b0, 1'b1);
        walk(MODE_ERROR, 1'b0, 1'b0, 1'b1);
        // charge / balance swaps, charge and discharge exits gated by the done inputs
        walk(MODE_CHARGE, 1'b0, 1'b0, 1'b0);
        walk(MODE_STANDBY, 1'b0, 1'b1, 1'b0);
        walk(MODE_BALANCE, 1'b0, 1'b0, 1'b0);
        walk(MODE_CHARGE, 1'b0, 1'b0, 1'b0);
        walk(MODE_DISCHARGE, 1'b1, 1'b1, 1'b0);
        walk(MODE_STANDBY, 1'b1, 1'b0, 1'b0);
        walk(MODE_BALANCE, 1'b0, 1'b0, 1'b0);
        walk(MODE_STANDBY, 1'b0, 1'b0, 1'b0);
        walk(MODE_DISCHARGE, 1'b0, 1'b0, 1'b0);
        walk(MODE_STANDBY, 1'b1, 1'b0, 1'b0);
        walk(MODE_CHARGE, 1'b1, 1'b1, 1'b0);
        walk(MODE_STANDBY, 1'b0, 1'b1, 1'b0);

        run_healthy(200);

        wait_drain();
        set_limits(8'hFF, 16'h0000, 16'hFFFF);
        write_reg(REG_UNUSED, $urandom);
        hold_req = 1'b1;
        run_healthy(240);

        wait_drain();
        set_limits(8'h00, 16'hFFFE, 16'h0001);
        quiet = 1'b1;
        run_healthy(100);
        quiet = 1'b0;
        run_healthy(100);

        repeat (4)
        begin
            wait_drain();
            set_limits(8'($urandom), 16'($urandom_range(0, 65534)),
                       16'($urandom_range(1, 65535)));
            run_healthy(200);
        end

        // faults: sticky error mode from the first one on
        wait_drain();
        set_limits(8'(limit_pick(16'h00FF)), limit_pick(16'hFFFF), limit_pick(16'hFFFF));
        repeat (250)
        begin
            t = healthy_tick(pick_request());
            case ($urandom_range(0, 99))
                0: t.storage_read_error = 1'b1;
                1: t.monitor_error = 1'b1;
                2: t.hottest_cell_c = 8'($urandom_range(int'(temp_lim) + 1, 255));
                3: t.lowest_cell_mv = 16'($urandom_range(0, min_lim));
                4: t.highest_cell_mv = 16'($urandom_range(max_lim, 65535));
                5, 6, 7, 8: t.substep_fault = 1'b1;
                9:
                begin
                    t.storage_read_error = 1'b1;
                    t.monitor_error = 1'b1;
                    t.substep_fault = 1'b1;
                    t.hottest_cell_c = 8'hFF;
                    t.lowest_cell_mv = '0;
                    t.highest_cell_mv = 16'hFFFF;
                end
                default: ;
            endcase
            send_tick(t);
        end
        repeat (150)
        begin
            raw = {$urandom, $urandom};
            send_tick(raw[$bits(tick_t)-1:0]);
        end

        wait_drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[battery_mode_supervisor.f]
sv/bms_pkg.sv
sv/bms_cfg_regs.sv
sv/bms_step.sv
sv/battery_mode_supervisor.sv
sim/supervisor_checker.sv
sim/tb_top.sv
